>>> hw/rtl/sqd_pkg.sv
// Package of the stack/queue store: sizes, command, result and error codes,
// and the control word that the top level hands to every storage cell.
// Depends on nothing; every other file imports it.
package sqd_pkg;

  localparam int unsigned DEPTH = 32;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    CMD_PUSH = 3'd0,
    CMD_LIST = 3'd1,
    CMD_PEEK = 3'd2,
    CMD_POP  = 3'd3,
    CMD_SWAP = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_DONE  = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_ERROR = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_NO_ARG     = 3'd1,
    ERR_FULL       = 3'd2,
    ERR_PEEK_EMPTY = 3'd3,
    ERR_POP_EMPTY  = 3'd4,
    ERR_SWAP_SHORT = 3'd5
  } err_e;

  // Operation applied by every cell of the chain at once.
  typedef enum logic [2:0] {
    CELL_HOLD        = 3'd0,
    CELL_SHIFT_BACK  = 3'd1,
    CELL_SHIFT_FRONT = 3'd2,
    CELL_WRITE       = 3'd3,
    CELL_SWAP        = 3'd4,
    CELL_ROTATE      = 3'd5
  } cell_op_e;

  typedef struct packed {
    cell_op_e                 op;
    logic [CNT_W-1:0]         count;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

>>> hw/rtl/sqd_cell.sv
// One storage cell of the chain: holds a single entry and takes its next
// value from itself, a neighbour, the front cell or the push data.
// Depends on sqd_pkg.
module sqd_cell (
  input  logic                              clk_i,
  input  sqd_pkg::cell_ctrl_t               ctrl_i,
  input  logic [sqd_pkg::IDX_W-1:0]         index_i,
  input  logic signed [sqd_pkg::DATA_W-1:0] prev_i,
  input  logic signed [sqd_pkg::DATA_W-1:0] next_i,
  input  logic signed [sqd_pkg::DATA_W-1:0] head_i,
  output logic signed [sqd_pkg::DATA_W-1:0] data_o
);
  import sqd_pkg::*;

  logic signed [DATA_W-1:0] data_q, data_d;
  logic [CNT_W-1:0]         pos;

  assign pos = CNT_W'(index_i);

  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      CELL_HOLD:        data_d = data_q;
      CELL_SHIFT_BACK:  data_d = prev_i;
      CELL_SHIFT_FRONT: data_d = next_i;
      CELL_WRITE: begin
        if (pos == ctrl_i.count) data_d = ctrl_i.value;
      end
      CELL_SWAP: begin
        if (pos == CNT_W'(0)) data_d = next_i;
        else if (pos == CNT_W'(1)) data_d = prev_i;
      end
      CELL_ROTATE: begin
        // The last occupied cell wraps round to the front value.
        if (pos == ctrl_i.count - CNT_W'(1)) data_d = head_i;
        else data_d = next_i;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

>>> hw/rtl/stack_queue_deque_engine.sv
// Top level of the stack/queue store: control, output register and the
// chain of storage cells. Depends on sqd_pkg and sqd_cell.
//
// The store holds up to DEPTH signed 32-bit entries in a row of cells, the
// front entry always sitting in cell 0. A push in stack mode shifts the whole
// row back by one and drops the new item into cell 0; in queue mode the cell
// just past the last entry captures it. A pop shifts the row forward, and a
// swap exchanges cells 0 and 1. Push, pop, peek, swap and any unused command
// code produce a single result item, so such items can be accepted on
// consecutive cycles as long as the output is not stalled and no list is
// running. A list command produces one result item per stored entry: the
// row is rotated by one cell per cycle while the output is not stalled and
// cell 0 is sent out each time, so the store is back in its original order
// after the last entry. The input stays stalled while the entries are listed
// and for as long as the output is stalled.
// An empty list gives a single empty-listing result. On an error the store
// is left untouched and a single error item reports the code. The mode
// register may be written at any time the block is idle; its port is always
// ready.
module stack_queue_deque_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic signed [31:0] push_value_i,
  input  logic        has_argument_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic signed [31:0] result_value_o,
  output logic [2:0]  error_code_o,
  output logic        last_result_o
);
  import sqd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LIST = 2'b10
  } state_e;

  state_e               state_q, state_d;
  logic                 queue_mode_q;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     left_q, left_d;

  logic                 out_valid_q, out_valid_d;
  kind_e                kind_q, kind_d;
  logic signed [DATA_W-1:0] value_q, value_d;
  err_e                 err_q, err_d;
  logic                 last_q, last_d;
  logic                 out_load;

  logic                 out_free;
  logic                 accept;
  cell_ctrl_t           cell_ctrl;
  logic signed [DATA_W-1:0] cell_data [DEPTH];

  // The configuration register is always writable.
  assign cfg_ready_o = 1'b1;

  // The output register can take a new item when empty or being emptied.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d         = state_q;
    count_d         = count_q;
    left_d          = left_q;
    out_load        = 1'b0;
    kind_d          = KIND_DONE;
    value_d         = '0;
    err_d           = ERR_NONE;
    last_d          = 1'b1;
    cell_ctrl.op    = CELL_HOLD;
    cell_ctrl.count = count_q;
    cell_ctrl.value = push_value_i;

    if (accept) begin
      out_load = 1'b1;
      case (command_i)
        CMD_PUSH: begin
          if (!has_argument_i) begin
            kind_d = KIND_ERROR;
            err_d  = ERR_NO_ARG;
          end else if (count_q == CNT_W'(DEPTH)) begin
            kind_d = KIND_ERROR;
            err_d  = ERR_FULL;
          end else begin
            cell_ctrl.op = queue_mode_q ? CELL_WRITE : CELL_SHIFT_BACK;
            count_d      = count_q + CNT_W'(1);
          end
        end
        CMD_LIST: begin
          if (count_q == '0) begin
            kind_d = KIND_EMPTY;
          end else begin
            // Entries go out one per cycle from the list state while the output is not stalled.
            out_load = 1'b0;
            state_d  = ST_LIST;
            left_d   = count_q;
          end
        end
        CMD_PEEK: begin
          if (count_q == '0) begin
            kind_d = KIND_ERROR;
            err_d  = ERR_PEEK_EMPTY;
          end else begin
            kind_d  = KIND_VALUE;
            value_d = cell_data[0];
          end
        end
        CMD_POP: begin
          if (count_q == '0) begin
            kind_d = KIND_ERROR;
            err_d  = ERR_POP_EMPTY;
          end else begin
            cell_ctrl.op = CELL_SHIFT_FRONT;
            count_d      = count_q - CNT_W'(1);
          end
        end
        CMD_SWAP: begin
          if (count_q < CNT_W'(2)) begin
            kind_d = KIND_ERROR;
            err_d  = ERR_SWAP_SHORT;
          end else begin
            cell_ctrl.op = CELL_SWAP;
          end
        end
        default: begin
          kind_d = KIND_DONE;
        end
      endcase
    end else if ((state_q == ST_LIST) && out_free) begin
      out_load     = 1'b1;
      kind_d       = KIND_VALUE;
      value_d      = cell_data[0];
      last_d       = (left_q == CNT_W'(1));
      cell_ctrl.op = CELL_ROTATE;
      left_d       = left_q - CNT_W'(1);
      if (left_q == CNT_W'(1)) state_d = ST_IDLE;
    end
  end

  always_comb begin
    if (out_load) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      queue_mode_q <= 1'b0;
      count_q      <= '0;
      left_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) queue_mode_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      kind_q  <= kind_d;
      value_q <= value_d;
      err_q   <= err_d;
      last_q  <= last_d;
    end
  end

  // Chain of storage cells; cell 0 holds the front entry.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] prev_data;
    logic signed [DATA_W-1:0] next_data;

    if (i == 0) begin : g_first
      assign prev_data = push_value_i;
    end else begin : g_mid_prev
      assign prev_data = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_data = '0;
    end else begin : g_mid_next
      assign next_data = cell_data[i+1];
    end

    sqd_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .index_i (IDX_W'(i)),
      .prev_i  (prev_data),
      .next_i  (next_data),
      .head_i  (cell_data[0]),
      .data_o  (cell_data[i])
    );
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = kind_q;
  assign result_value_o = value_q;
  assign error_code_o   = err_q;
  assign last_result_o  = last_q;

endmodule
